/* design/sem_pkg.sv */
`default_nettype none

package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int WINDOW     = 3;
    localparam int COEF_BITS  = 7;

    // Grey history: two full rows plus the three pixels of the window's edge.
    localparam int HIST      = 2 * MAX_WIDTH + 3;
    localparam int ADDR_BITS = $clog2(HIST);
    localparam int SUM_BITS  = ADDR_BITS + 2;

    // Register widths as seen on the configuration port.
    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 13;
    localparam int KERNEL_BITS = 63;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 63;

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int ROW_BITS = $clog2(MAX_HEIGHT);

    localparam int TAPS      = WINDOW * WINDOW;
    localparam int STEP_BITS = $clog2(TAPS + 1);
    localparam int TAP_BITS  = $clog2(TAPS);

    localparam int PROD_BITS = COEF_BITS + 9;
    localparam int ACC_BITS  = PROD_BITS + 4;
    localparam int SQ_BITS   = 17;

    // floor(s/3) for s up to 765 as (s * 683) >> 11.
    localparam int GREY_RECIP = 683;
    localparam int GREY_SHIFT = 11;

    localparam logic [WIDTH_BITS-1:0]  RESET_WIDTH  = WIDTH_BITS'(640);
    localparam logic [HEIGHT_BITS-1:0] RESET_HEIGHT = HEIGHT_BITS'(480);

    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_X     = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_Y     = 2'd3;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] magnitude;
        logic       frame_end;
    } t_out_item;

    // Window row and column of a tap number, row-major.
    function automatic logic [1:0] tap_row(input logic [STEP_BITS-1:0] s);
        logic [1:0] r;
        if (s < STEP_BITS'(3)) begin
            r = 2'd0;
        end else if (s < STEP_BITS'(6)) begin
            r = 2'd1;
        end else begin
            r = 2'd2;
        end
        return r;
    endfunction

    function automatic logic [1:0] tap_col(input logic [STEP_BITS-1:0] s);
        logic [STEP_BITS-1:0] c;
        c = s - STEP_BITS'(3) * STEP_BITS'(tap_row(s));
        return c[1:0];
    endfunction

    function automatic logic signed [COEF_BITS-1:0] coef(
        input logic [KERNEL_BITS-1:0] packed_k,
        input logic [TAP_BITS-1:0]    k
    );
        return $signed(packed_k[k*COEF_BITS +: COEF_BITS]);
    endfunction

endpackage

`default_nettype wire

/* design/sem_line_ram.sv */
`default_nettype none

module sem_line_ram #(
    parameter int DEPTH = 2051,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/sem_isqrt.sv */
`default_nettype none

module sem_isqrt (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [sem_pkg::SQ_BITS-1:0] i_value,
    output logic                        o_done,
    output logic [7:0]                  o_root
);

    import sem_pkg::*;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [2:0]         r_idx, n_idx;
    logic [7:0]         r_root, n_root;
    logic [SQ_BITS-1:0] r_value, n_value;
    logic [7:0]         trial;
    logic [15:0]        trial_sq;

    // One result bit per cycle, most significant first. The root is capped
    // at 255 by construction: only eight bits are ever tried.
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_idx   = r_idx;
        n_root  = r_root;
        n_value = r_value;
        trial    = r_root | (8'd1 << r_idx);
        trial_sq = {8'd0, trial} * {8'd0, trial};
        if (i_start) begin
            n_busy  = 1'b1;
            n_idx   = 3'd7;
            n_root  = 8'd0;
            n_value = i_value;
        end else if (r_busy) begin
            if ({1'b0, trial_sq} <= r_value) begin
                n_root = trial;
            end
            if (r_idx == 3'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_idx = r_idx - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_root  <= n_root;
        r_value <= n_value;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

/* design/sobel_edge_magnitude.sv */
`default_nettype none

// Channel   Direction  Signals                                   Payload
// config    in         i_cfg_valid / o_cfg_ready                 i_cfg_index, i_cfg_data
// request   in         i_in_valid  / o_in_ready                  i_in  (t_in_item)
// result    out        o_out_valid / i_out_ready                 o_out (t_out_item)
//
// A pixel that yields no result, and an ignored request, leave the block idle.
// A request that yields a result is worked through before the next is taken:
// nine window taps read one per cycle through the single read port of the
// line store, a square step, and eight steps of the root unit.
// Reset is synchronous; the line store is not cleared and needs no pass.
// The result register lets requests be taken while a result waits, but a
// finished result that finds it still full holds the block, taking no requests.

module sobel_edge_magnitude (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [sem_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  wire logic [sem_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire sem_pkg::t_in_item                  i_in,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output sem_pkg::t_out_item                      o_out
);

    import sem_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_SQUARE = 5'b00100,
        S_ROOT   = 5'b01000,
        S_HOLD   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [WIDTH_BITS-1:0]  r_width, n_width;
    logic [HEIGHT_BITS-1:0] r_height, n_height;
    logic [KERNEL_BITS-1:0] r_kx, n_kx;
    logic [KERNEL_BITS-1:0] r_ky, n_ky;

    logic [COL_BITS-1:0]  r_col, n_col;
    logic [ROW_BITS-1:0]  r_row, n_row;
    logic [COL_BITS-1:0]  r_out_col, n_out_col;
    logic [ROW_BITS-1:0]  r_out_row, n_out_row;
    logic                 r_frame_in, n_frame_in;
    logic [ADDR_BITS-1:0] r_wptr, n_wptr;
    logic [ADDR_BITS-1:0] r_cptr, n_cptr;

    logic [STEP_BITS-1:0]       r_step, n_step;
    logic                       r_rd_vld, n_rd_vld;
    logic                       r_rd_in, n_rd_in;
    logic [TAP_BITS-1:0]        r_rd_k, n_rd_k;
    logic signed [ACC_BITS-1:0] r_gx, n_gx;
    logic signed [ACC_BITS-1:0] r_gy, n_gy;
    logic [7:0]                 r_mag, n_mag;

    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic in_acc, cfg_acc;
    logic [9:0]  rgb_sum;
    logic [19:0] grey_prod;
    logic [7:0]  grey;
    logic        col_last, row_last, out_col_last, out_row_last, out_last;

    logic [1:0]                 kr, kc;
    logic                       tap_in;
    logic signed [SUM_BITS-1:0] row_off, rd_sum, rd_wrap;
    logic [ADDR_BITS-1:0]       rd_addr;

    logic                        mem_we, mem_re;
    logic [7:0]                  mem_rdata, tap_grey;
    logic signed [PROD_BITS-1:0] prod_x, prod_y;

    logic [7:0]         ax, ay;
    logic [SQ_BITS-1:0] sq_value;
    logic               sq_start, sq_done;
    logic [7:0]         sq_root;

    logic [WIDTH_BITS-1:0]  cfg_w;
    logic [HEIGHT_BITS-1:0] cfg_h;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    assign rgb_sum   = {2'b0, i_in.red} + {2'b0, i_in.green} + {2'b0, i_in.blue};
    assign grey_prod = {10'd0, rgb_sum} * 20'(GREY_RECIP);
    assign grey      = grey_prod[GREY_SHIFT +: 8];

    assign col_last     = ({1'b0, r_col} == r_width - WIDTH_BITS'(1));
    assign row_last     = ({1'b0, r_row} == r_height - HEIGHT_BITS'(1));
    assign out_col_last = ({1'b0, r_out_col} == r_width - WIDTH_BITS'(1));
    assign out_row_last = ({1'b0, r_out_row} == r_height - HEIGHT_BITS'(1));
    assign out_last     = out_col_last && out_row_last;

    // Tap address around the centre entry, wrapped into the circular store.
    // Taps outside the frame read anything and are masked to zero.
    always_comb begin
        kr = tap_row(r_step);
        kc = tap_col(r_step);
        tap_in = !(kr == 2'd0 && r_out_row == '0) && !(kr == 2'd2 && out_row_last)
              && !(kc == 2'd0 && r_out_col == '0) && !(kc == 2'd2 && out_col_last);
        case (kr)
            2'd0:    row_off = -$signed({{(SUM_BITS-WIDTH_BITS){1'b0}}, r_width});
            2'd2:    row_off = $signed({{(SUM_BITS-WIDTH_BITS){1'b0}}, r_width});
            default: row_off = '0;
        endcase
        rd_sum = $signed({2'b0, r_cptr}) + row_off
               + $signed(SUM_BITS'(kc)) - $signed(SUM_BITS'(1));
        if (rd_sum < 0) begin
            rd_wrap = rd_sum + $signed(SUM_BITS'(HIST));
        end else if (rd_sum >= $signed(SUM_BITS'(HIST))) begin
            rd_wrap = rd_sum - $signed(SUM_BITS'(HIST));
        end else begin
            rd_wrap = rd_sum;
        end
        rd_addr = rd_wrap[ADDR_BITS-1:0];
    end

    assign tap_grey = r_rd_in ? mem_rdata : 8'd0;
    assign prod_x   = coef(r_kx, r_rd_k) * $signed({1'b0, tap_grey});
    assign prod_y   = coef(r_ky, r_rd_k) * $signed({1'b0, tap_grey});

    assign ax = (r_gx < 0) ? 8'd0 : (r_gx > $signed(ACC_BITS'(255))) ? 8'd255 : r_gx[7:0];
    assign ay = (r_gy < 0) ? 8'd0 : (r_gy > $signed(ACC_BITS'(255))) ? 8'd255 : r_gy[7:0];
    assign sq_value = ({9'd0, ax} * {9'd0, ax}) + ({9'd0, ay} * {9'd0, ay});

    always_comb begin
        cfg_w = i_cfg_data[WIDTH_BITS-1:0];
        if (cfg_w == '0) begin
            cfg_w = WIDTH_BITS'(1);
        end else if (cfg_w > WIDTH_BITS'(MAX_WIDTH)) begin
            cfg_w = WIDTH_BITS'(MAX_WIDTH);
        end
        cfg_h = i_cfg_data[HEIGHT_BITS-1:0];
        if (cfg_h == '0) begin
            cfg_h = HEIGHT_BITS'(1);
        end else if (cfg_h > HEIGHT_BITS'(MAX_HEIGHT)) begin
            cfg_h = HEIGHT_BITS'(MAX_HEIGHT);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_width     = r_width;
        n_height    = r_height;
        n_kx        = r_kx;
        n_ky        = r_ky;
        n_col       = r_col;
        n_row       = r_row;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_frame_in  = r_frame_in;
        n_wptr      = r_wptr;
        n_cptr      = r_cptr;
        n_step      = r_step;
        n_rd_vld    = 1'b0;
        n_rd_in     = r_rd_in;
        n_rd_k      = r_rd_k;
        n_gx        = r_gx;
        n_gy        = r_gy;
        n_mag       = r_mag;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        sq_start    = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // A tap read in the previous cycle lands in the accumulators now.
        if (r_rd_vld) begin
            n_gx = r_gx + ACC_BITS'(prod_x);
            n_gy = r_gy + ACC_BITS'(prod_y);
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.kind == KIND_PIXEL) begin
                        if (!r_frame_in) begin
                            mem_we = 1'b1;
                            if (col_last && row_last) begin
                                n_frame_in = 1'b1;
                                n_col      = '0;
                                n_row      = '0;
                                n_wptr     = '0;
                            end else begin
                                n_wptr = (r_wptr == ADDR_BITS'(HIST - 1)) ? '0
                                       : r_wptr + ADDR_BITS'(1);
                                if (col_last) begin
                                    n_col = '0;
                                    n_row = r_row + ROW_BITS'(1);
                                end else begin
                                    n_col = r_col + COL_BITS'(1);
                                end
                            end
                            // Results trail the input by one row and one pixel.
                            if (r_row >= ROW_BITS'(2) || (r_row == ROW_BITS'(1) && r_col != '0)) begin
                                n_state = S_READ;
                                n_step  = '0;
                                n_gx    = '0;
                                n_gy    = '0;
                            end
                        end
                    end else if (r_frame_in) begin
                        n_state = S_READ;
                        n_step  = '0;
                        n_gx    = '0;
                        n_gy    = '0;
                    end
                end
            end
            S_READ: begin
                if (r_step == STEP_BITS'(TAPS)) begin
                    n_state = S_SQUARE;
                end else begin
                    mem_re   = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_in  = tap_in;
                    n_rd_k   = r_step[TAP_BITS-1:0];
                    n_step   = r_step + STEP_BITS'(1);
                end
            end
            S_SQUARE: begin
                sq_start = 1'b1;
                n_state  = S_ROOT;
            end
            S_ROOT: begin
                if (sq_done) begin
                    n_mag   = sq_root;
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid     = 1'b1;
                    n_out.magnitude = r_mag;
                    n_out.frame_end = out_last;
                    n_state         = S_IDLE;
                    if (out_last) begin
                        n_col      = '0;
                        n_row      = '0;
                        n_out_col  = '0;
                        n_out_row  = '0;
                        n_frame_in = 1'b0;
                        n_wptr     = '0;
                        n_cptr     = '0;
                    end else begin
                        n_cptr = (r_cptr == ADDR_BITS'(HIST - 1)) ? '0
                               : r_cptr + ADDR_BITS'(1);
                        if (out_col_last) begin
                            n_out_col = '0;
                            n_out_row = r_out_row + ROW_BITS'(1);
                        end else begin
                            n_out_col = r_out_col + COL_BITS'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cfg_acc) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH: begin
                    n_width = cfg_w;
                end
                CFG_IMAGE_HEIGHT: begin
                    n_height = cfg_h;
                end
                CFG_KERNEL_X: begin
                    n_kx = i_cfg_data[KERNEL_BITS-1:0];
                end
                CFG_KERNEL_Y: begin
                    n_ky = i_cfg_data[KERNEL_BITS-1:0];
                end
                default: begin
                end
            endcase
            // A size change abandons the frame in progress.
            if (i_cfg_index == CFG_IMAGE_WIDTH || i_cfg_index == CFG_IMAGE_HEIGHT) begin
                n_col      = '0;
                n_row      = '0;
                n_out_col  = '0;
                n_out_row  = '0;
                n_frame_in = 1'b0;
                n_wptr     = '0;
                n_cptr     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= RESET_WIDTH;
            r_height    <= RESET_HEIGHT;
            r_kx        <= '0;
            r_ky        <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_frame_in  <= 1'b0;
            r_wptr      <= '0;
            r_cptr      <= '0;
            r_step      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_width     <= n_width;
            r_height    <= n_height;
            r_kx        <= n_kx;
            r_ky        <= n_ky;
            r_col       <= n_col;
            r_row       <= n_row;
            r_out_col   <= n_out_col;
            r_out_row   <= n_out_row;
            r_frame_in  <= n_frame_in;
            r_wptr      <= n_wptr;
            r_cptr      <= n_cptr;
            r_step      <= n_step;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_in <= n_rd_in;
        r_rd_k  <= n_rd_k;
        r_gx    <= n_gx;
        r_gy    <= n_gy;
        r_mag   <= n_mag;
        r_out   <= n_out;
    end

    sem_line_ram #(
        .DEPTH (HIST),
        .WIDTH (8)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wptr),
        .i_wdata (grey),
        .i_re    (mem_re),
        .i_raddr (rd_addr),
        .o_rdata (mem_rdata)
    );

    sem_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_value),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

/* design/sem_checker.sv */
`default_nettype none

module sem_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_cfg_valid,
    input wire logic                               o_cfg_ready,
    input wire logic [sem_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input wire logic [sem_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input wire logic                               i_in_valid,
    input wire logic                               o_in_ready,
    input wire sem_pkg::t_in_item                  i_in,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_ready,
    input wire sem_pkg::t_out_item                 o_out
);

    import sem_pkg::*;

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // Reset empties the result register and opens the request side.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset did not clear the block");

    // A new result only appears after the block was busy computing it.
    a_new_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without computation");

    // A freshly loaded result finds the block ready for the next request.
    a_busy_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !$past(o_out_valid) |-> o_in_ready)
        else $error("block still busy after loading a result");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (.*);

`default_nettype wire

/* dv/sobel_edge_magnitude_tb.sv */
`default_nettype none

module sobel_edge_magnitude_tb;
    import sem_pkg::*;

    localparam int LIMIT_CYCLES  = 2_500_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 600;
    localparam int MAX_REPORTS   = 10;

    typedef enum logic {ROW_REG, ROW_REQ} row_e;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_VALUE} chk_e;

    typedef struct {
        row_e                     what;
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] data;
        t_in_item                 item;
        chk_e                     check;
        t_out_item                want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    t_in_item in_item = '0;
    logic out_ready = 1'b0;
    logic cfg_ready, in_ready, out_valid;
    t_out_item out_item;

    // Predictor state: registers, grey history and frame positions.
    logic [WIDTH_BITS-1:0]  p_width = RESET_WIDTH;
    logic [HEIGHT_BITS-1:0] p_height = RESET_HEIGHT;
    logic [KERNEL_BITS-1:0] p_kx = '0;
    logic [KERNEL_BITS-1:0] p_ky = '0;
    logic [7:0] grey_hist [HIST];
    int in_col = 0, in_row = 0, out_col = 0, out_row = 0;
    bit frame_full = 1'b0;

    t_out_item pending[$];
    dir_row_t dir_rows[$];

    int in_idle_pct = 0, out_idle_pct = 0;
    int hold_requests = 0, holds_served = 0, hold_left = 0;
    int fail_count = 0, reqs_sent = 0, results_seen = 0, frames_done = 0, sizes_set = 0;
    int cycle_count = 0;
    bit cfg_open = 1'b0;

    sobel_edge_magnitude i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int eff_width();
        if (p_width == 0) return 1;
        if (p_width > MAX_WIDTH) return MAX_WIDTH;
        return int'(p_width);
    endfunction

    function automatic int eff_height();
        if (p_height == 0) return 1;
        if (p_height > MAX_HEIGHT) return MAX_HEIGHT;
        return int'(p_height);
    endfunction

    function automatic void restart_frame();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        frame_full = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] val);
        case (idx)
            CFG_IMAGE_WIDTH: begin
                p_width = val[WIDTH_BITS-1:0];
                restart_frame();
            end
            CFG_IMAGE_HEIGHT: begin
                p_height = val[HEIGHT_BITS-1:0];
                restart_frame();
            end
            CFG_KERNEL_X: p_kx = val[KERNEL_BITS-1:0];
            CFG_KERNEL_Y: p_ky = val[KERNEL_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] center_magnitude(input int w, input int h);
        int gx, gy, r, c, g, k, dr, dc, ax, ay, sq, root, b;
        logic signed [COEF_BITS-1:0] cx, cy;
        gx = 0;
        gy = 0;
        for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
                r = out_row + dr;
                c = out_col + dc;
                k = (dr + 1) * WINDOW + (dc + 1);
                // Taps outside the frame read as zero.
                g = (r >= 0 && r < h && c >= 0 && c < w) ? int'(grey_hist[(r * w + c) % HIST]) : 0;
                cx = p_kx[k*COEF_BITS +: COEF_BITS];
                cy = p_ky[k*COEF_BITS +: COEF_BITS];
                gx += int'(cx) * g;
                gy += int'(cy) * g;
            end
        end
        ax = (gx < 0) ? 0 : (gx > 255) ? 255 : gx;
        ay = (gy < 0) ? 0 : (gy > 255) ? 255 : gy;
        sq = ax * ax + ay * ay;
        root = 0;
        for (b = 8; b >= 0; b--) begin
            if ((root + (1 << b)) * (root + (1 << b)) <= sq) root += 1 << b;
        end
        return (root > 255) ? 8'd255 : 8'(root);
    endfunction

    // Advances the predictor by one accepted request; returns 1 if it yields a result.
    function automatic bit sobel_step(input t_in_item it, output t_out_item res);
        int w, h, n;
        bit last;
        w = eff_width();
        h = eff_height();
        res = '0;
        if (it.kind == KIND_PIXEL) begin
            if (frame_full) return 1'b0;
            n = in_row * w + in_col;
            grey_hist[n % HIST] = 8'((int'(it.red) + int'(it.green) + int'(it.blue)) / 3);
            if (in_col == w - 1 && in_row == h - 1) begin
                frame_full = 1'b1;
                in_col = 0;
                in_row = 0;
            end else begin
                in_col++;
                if (in_col >= w) begin
                    in_col = 0;
                    in_row++;
                end
            end
            if (n < w + 1) return 1'b0;
        end else if (!frame_full) begin
            return 1'b0;
        end
        res.magnitude = center_magnitude(w, h);
        last = (out_col == w - 1) && (out_row == h - 1);
        res.frame_end = last;
        if (last) begin
            restart_frame();
            frames_done++;
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        return 1'b1;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("Mismatch at cycle %0d: %s", cycle_count, msg);
    endfunction

    function automatic dir_row_t reg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                         input logic [CFG_DATA_BITS-1:0] val);
        dir_row_t r;
        r.what = ROW_REG;
        r.index = idx;
        r.data = val;
        r.item = '0;
        r.check = CHK_NONE;
        r.want = '0;
        return r;
    endfunction

    function automatic dir_row_t req_row(input logic kind, input logic [7:0] red,
                                         input logic [7:0] green, input logic [7:0] blue,
                                         input chk_e chk, input logic [7:0] mag,
                                         input logic fe);
        dir_row_t r;
        r.what = ROW_REQ;
        r.index = '0;
        r.data = '0;
        r.item.kind = kind;
        r.item.red = red;
        r.item.green = green;
        r.item.blue = blue;
        r.check = chk;
        r.want.magnitude = mag;
        r.want.frame_end = fe;
        return r;
    endfunction

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_in_item rand_item(input logic kind);
        t_in_item it;
        it.kind = kind;
        it.red = rand_chan();
        it.green = rand_chan();
        it.blue = rand_chan();
        return it;
    endfunction

    // Classic gradient kernels with random sign, small random taps, or raw random bits.
    function automatic logic [KERNEL_BITS-1:0] rand_kernel();
        logic [KERNEL_BITS-1:0] kv;
        int k, c, mode, sgn;
        mode = $urandom_range(3);
        sgn = $urandom_range(1) ? 1 : -1;
        kv = KERNEL_BITS'({$urandom, $urandom});
        if (mode != 3) begin
            for (k = 0; k < TAPS; k++) begin
                case (mode)
                    0: c = sgn * (k % 3 - 1) * ((k / 3 == 1) ? 2 : 1);
                    1: c = sgn * (k / 3 - 1) * ((k % 3 == 1) ? 2 : 1);
                    default: c = int'($urandom_range(6)) - 3;
                endcase
                kv[k*COEF_BITS +: COEF_BITS] = COEF_BITS'(c);
            end
        end
        return kv;
    endfunction

    task automatic send_req(input t_in_item it, input chk_e chk, input t_out_item want);
        t_out_item res;
        bit got;
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (!in_ready);
        got = sobel_step(it, res);
        reqs_sent++;
        case (chk)
            CHK_MODEL: if (got) pending.push_back(res);
            CHK_VALUE: pending.push_back(want);
            default: ;
        endcase
    endtask

    task automatic send(input t_in_item it);
        send_req(it, CHK_MODEL, '0);
    endtask

    // Waits for every expected result to come out, then settles further before
    // touching the registers.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, val);
    endtask

    task automatic load_setting(input int wr_w, input int wr_h,
                                input logic [KERNEL_BITS-1:0] kx,
                                input logic [KERNEL_BITS-1:0] ky);
        wait_idle();
        write_reg(CFG_KERNEL_X, CFG_DATA_BITS'(kx));
        write_reg(CFG_KERNEL_Y, CFG_DATA_BITS'(ky));
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_BITS'(wr_w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_BITS'(wr_h));
        cfg_valid <= 1'b0;
        sizes_set++;
    endtask

    // One frame of requests; when noisy, adds stray flushes and pixels and may cut it short.
    task automatic send_frame(input int w, input int h, input bit noisy);
        int need, cut, n;
        need = (h == 1) ? w : w + 1;
        cut = (noisy && $urandom_range(19) == 0) ? int'($urandom_range(w * h - 1)) : -1;
        if (noisy && $urandom_range(9) == 0) send(rand_item(KIND_FLUSH));
        for (n = 0; n < w * h; n++) begin
            if (n == cut) return;
            if (noisy && $urandom_range(39) == 0) send(rand_item(KIND_FLUSH));
            send(rand_item(KIND_PIXEL));
        end
        if (noisy && $urandom_range(9) == 0) send(rand_item(KIND_PIXEL));
        repeat (need) send(rand_item(KIND_FLUSH));
        if (noisy && $urandom_range(7) == 0) send(rand_item(KIND_FLUSH));
    endtask

    // Result side: random stalls, plus one long hold-off on request from the stimulus.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (pending.size() == 0) begin
                note_failure($sformatf("unexpected result magnitude %0d frame_end %0b",
                                       out_item.magnitude, out_item.frame_end));
            end else begin
                want = pending.pop_front();
                if (out_item.magnitude !== want.magnitude)
                    note_failure($sformatf("magnitude expected %0d got %0d",
                                           want.magnitude, out_item.magnitude));
                if (out_item.frame_end !== want.frame_end)
                    note_failure($sformatf("frame_end expected %0b got %0b",
                                           want.frame_end, out_item.frame_end));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timed out with %0d results still owed.", pending.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        int mode, phase, frames, w, h;
        // Zero kernels after reset give zero everywhere; later rows saturate both clamps.
        dir_rows.push_back(reg_row(CFG_IMAGE_WIDTH, 3));
        dir_rows.push_back(reg_row(CFG_IMAGE_HEIGHT, 3));
        dir_rows.push_back(req_row(KIND_FLUSH, 8'hFF, 8'hFF, 8'hFF, CHK_NONE, 0, 0));
        dir_rows.push_back(req_row(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, CHK_NONE, 0, 0));
        dir_rows.push_back(req_row(KIND_PIXEL, 8'h00, 8'h00, 8'h00, CHK_NONE, 0, 0));
        dir_rows.push_back(req_row(KIND_PIXEL, 8'hFF, 8'h00, 8'h00, CHK_NONE, 0, 0));
        dir_rows.push_back(req_row(KIND_PIXEL, 8'h00, 8'hFF, 8'h00, CHK_NONE, 0, 0));
        dir_rows.push_back(req_row(KIND_PIXEL, 8'h00, 8'h00, 8'hFF, CHK_VALUE, 0, 0));
        dir_rows.push_back(req_row(KIND_PIXEL, 8'h01, 8'h02, 8'h03, CHK_VALUE, 0, 0));
        dir_rows.push_back(req_row(KIND_PIXEL, 8'h80, 8'h80, 8'h80, CHK_VALUE, 0, 0));
        dir_rows.push_back(req_row(KIND_PIXEL, 8'hFE, 8'hFE, 8'hFE, CHK_VALUE, 0, 0));
        dir_rows.push_back(req_row(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFE, CHK_VALUE, 0, 0));
        dir_rows.push_back(req_row(KIND_PIXEL, 8'h55, 8'hAA, 8'h55, CHK_NONE, 0, 0));
        dir_rows.push_back(req_row(KIND_FLUSH, 8'h00, 8'h00, 8'h00, CHK_VALUE, 0, 0));
        dir_rows.push_back(req_row(KIND_FLUSH, 8'h00, 8'h00, 8'h00, CHK_VALUE, 0, 0));
        dir_rows.push_back(req_row(KIND_FLUSH, 8'h00, 8'h00, 8'h00, CHK_VALUE, 0, 0));
        dir_rows.push_back(req_row(KIND_FLUSH, 8'h00, 8'h00, 8'h00, CHK_VALUE, 0, 1));
        dir_rows.push_back(req_row(KIND_FLUSH, 8'hAA, 8'h55, 8'hAA, CHK_NONE, 0, 0));
        // Zero sizes count as one; most negative horizontal taps, largest vertical taps.
        dir_rows.push_back(reg_row(CFG_IMAGE_WIDTH, 0));
        dir_rows.push_back(reg_row(CFG_IMAGE_HEIGHT, 0));
        dir_rows.push_back(reg_row(CFG_KERNEL_X, CFG_DATA_BITS'({TAPS{7'h40}})));
        dir_rows.push_back(reg_row(CFG_KERNEL_Y, CFG_DATA_BITS'({TAPS{7'h3F}})));
        dir_rows.push_back(req_row(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, CHK_NONE, 0, 0));
        dir_rows.push_back(req_row(KIND_FLUSH, 8'h00, 8'h00, 8'h00, CHK_VALUE, 255, 1));
        dir_rows.push_back(reg_row(CFG_KERNEL_X, CFG_DATA_BITS'({TAPS{7'h3F}})));
        dir_rows.push_back(req_row(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF, CHK_NONE, 0, 0));
        dir_rows.push_back(req_row(KIND_FLUSH, 8'h00, 8'h00, 8'h00, CHK_VALUE, 255, 1));
        dir_rows.push_back(req_row(KIND_PIXEL, 8'h00, 8'h00, 8'h00, CHK_NONE, 0, 0));
        dir_rows.push_back(req_row(KIND_FLUSH, 8'hFF, 8'hFF, 8'hFF, CHK_VALUE, 0, 1));

        in_idle_pct = 37;
        out_idle_pct = 84;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].what == ROW_REG) begin
                if (!cfg_open) begin
                    wait_idle();
                    cfg_open = 1'b1;
                end
                write_reg(dir_rows[i].index, dir_rows[i].data);
            end else begin
                if (cfg_open) begin
                    cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                    sizes_set++;
                end
                send_req(dir_rows[i].item, dir_rows[i].check, dir_rows[i].want);
            end
        end

        for (mode = 0; mode < 3; mode++) begin
            in_idle_pct = (mode == 0) ? 37 : (mode == 1) ? 84 : 0;
            out_idle_pct = (mode == 0) ? 84 : (mode == 1) ? 37 : 0;
            for (phase = 0; phase < 4; phase++) begin
                w = $urandom_range(1, 10);
                h = $urandom_range(1, 6);
                load_setting((w == 1 && $urandom_range(1)) ? 0 : w,
                             (h == 1 && $urandom_range(1)) ? 0 : h,
                             rand_kernel(), rand_kernel());
                // Stall the result side long enough for the block to back up its input.
                if (mode == 2 && phase == 0) hold_requests++;
                for (frames = 0; frames < 5; frames++) send_frame(w, h, 1'b1);
            end
        end

        // Largest sizes, written both exactly and out of range.
        load_setting(2047, 2, rand_kernel(), rand_kernel());
        send_frame(MAX_WIDTH, 2, 1'b0);
        load_setting(MAX_WIDTH, 3, rand_kernel(), rand_kernel());
        send_frame(MAX_WIDTH, 3, 1'b0);
        load_setting(1, 8191, rand_kernel(), rand_kernel());
        send_frame(1, MAX_HEIGHT, 1'b0);

        in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d results from %0d requests over %0d frames and %0d size settings.",
                 results_seen, reqs_sent, frames_done, sizes_set);
        $display("Sizes ran from one pixel to full-width rows and full-height columns.");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches in total.", fail_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
